FILE: src/imrs_pkg.sv
// Shared types, codes and helpers of the image scaler.
package imrs_pkg;

   // Request codes carried on req_type.
   localparam logic REQ_LOAD    = 1'b0;
   localparam logic REQ_COMPUTE = 1'b1;

   // Result status codes.
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   // Scale mode codes.
   localparam logic MODE_NEAREST  = 1'b0;
   localparam logic MODE_BILINEAR = 1'b1;

   // Register map of the configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 9;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_MODE    = 3'd4;

   // Upper bound of the target size registers.
   localparam logic [8:0] TARGET_LIMIT = 9'd256;

   // The divider produces a quotient with eight fraction bits below the integer part.
   localparam int DIV_W     = 25;
   localparam int DIV_STEPS = DIV_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_X,
      ST_DIV_Y,
      ST_FETCH,
      ST_MAC
   } state_type;

   // A size of zero acts as one, and a size beyond the limit saturates.
   function automatic logic [8:0] clamp_size(input logic [8:0] value,
                                             input logic [8:0] limit);
      logic [8:0] res;
      if (value == 9'd0) begin
         res = 9'd1;
      end else if (value > limit) begin
         res = limit;
      end else begin
         res = value;
      end
      return res;
   endfunction

endpackage

FILE: src/image_resize_bilinear_nearest.sv
// Top level of the image scaler: source pixel store, shared divider and blend sequencer.
// A load leaves the block idle and ready for the next word.
// A compute word outside the target size gives its result in the cycle after acceptance.
// A compute runs two 25-step restoring divisions on one shared divider, then one store
// read per neighbour: one neighbour in nearest mode, four in bilinear mode.
// busy falls in the cycle of the result strobe, and the receiver cannot stall results.
// Synchronous reset restores the size and mode registers and the sequencer; the store is not cleared.
module image_resize_bilinear_nearest
   import imrs_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_type,
   input  logic [7:0]             req_load_col,
   input  logic [7:0]             req_load_row,
   input  logic [31:0]            req_load_pixel,
   input  logic [7:0]             req_out_col,
   input  logic [7:0]             req_out_row,
   // Result channel.
   output logic                   rsp_valid,
   output logic [31:0]            rsp_result_pixel,
   output logic                   rsp_status,
   // Configuration channel.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   // The store holds MAX_WIDTH * MAX_HEIGHT pixels at address row * MAX_WIDTH + col.
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   // Source sizes saturate to the store size, capped at 511, the most a nine-bit register holds.
   localparam logic [8:0] SRC_W_LIMIT = 9'((MAX_WIDTH > 511) ? 511 : MAX_WIDTH);
   localparam logic [8:0] SRC_H_LIMIT = 9'((MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT);

   // Configuration registers.
   logic [8:0] src_w_ff;
   logic [8:0] src_h_ff;
   logic [8:0] tgt_w_ff;
   logic [8:0] tgt_h_ff;
   logic       mode_ff;

   // Sequencer state and working registers.
   state_type   state_ff, state_in;
   logic [7:0]  y_ff, y_in;
   logic [DIV_W-1:0] dq_ff, dq_in;
   logic [7:0]  rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [8:0]  x1_ff, x1_in;
   logic [7:0]  dx_ff, dx_in;
   logic [8:0]  y1_ff, y1_in;
   logic [7:0]  dy_ff, dy_in;
   logic [1:0]  nbr_ff, nbr_in;
   logic [16:0] weight_ff, weight_in;
   logic [23:0] acc_r_ff, acc_r_in;
   logic [23:0] acc_g_ff, acc_g_in;
   logic [23:0] acc_b_ff, acc_b_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_pixel_ff, rsp_pixel_in;
   logic        rsp_status_ff, rsp_status_in;

   // Pixel store.
   logic [31:0] store_mem [DEPTH];
   logic [31:0] rd_data_ff;
   logic [AW-1:0] mem_addr;
   logic          mem_we;

   // Combinational helpers.
   logic        accept;
   logic [8:0]  divisor;
   logic [8:0]  trial;
   logic        qbit;
   logic [7:0]  rem_next;
   logic [DIV_W-1:0] dq_next;
   logic [8:0]  x_scale;
   logic [8:0]  y_scale;
   logic [9:0]  x1_inc;
   logic [9:0]  y1_inc;
   logic [8:0]  x2;
   logic [8:0]  y2;
   logic [8:0]  fetch_col;
   logic [8:0]  fetch_row;
   logic [AW-1:0] fetch_addr;
   logic [AW-1:0] load_addr;
   logic        load_in_store;
   logic [8:0]  wx;
   logic [8:0]  wy;
   logic [17:0] weight_full;
   logic [24:0] prod_r;
   logic [24:0] prod_g;
   logic [24:0] prod_b;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_pixel = rsp_pixel_ff;
   assign rsp_status       = rsp_status_ff;

   // Configuration writes. Sizes are clamped as they are written.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= 9'd1;
         src_h_ff <= 9'd1;
         tgt_w_ff <= 9'd1;
         tgt_h_ff <= 9'd1;
         mode_ff  <= MODE_BILINEAR;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SOURCE_WIDTH:  src_w_ff <= clamp_size(csr_write_data, SRC_W_LIMIT);
            CSR_SOURCE_HEIGHT: src_h_ff <= clamp_size(csr_write_data, SRC_H_LIMIT);
            CSR_TARGET_WIDTH:  tgt_w_ff <= clamp_size(csr_write_data, TARGET_LIMIT);
            CSR_TARGET_HEIGHT: tgt_h_ff <= clamp_size(csr_write_data, TARGET_LIMIT);
            CSR_SCALE_MODE:    mode_ff  <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   // The scale factor is the source size in bilinear mode and one less in nearest mode.
   assign x_scale = (mode_ff == MODE_BILINEAR) ? src_w_ff : src_w_ff - 9'd1;
   assign y_scale = (mode_ff == MODE_BILINEAR) ? src_h_ff : src_h_ff - 9'd1;

   // One step of the shared restoring divider. The dividend is the scaled coordinate
   // shifted left by eight, so the quotient carries the integer part above an
   // eight-bit fraction: floor(n * 256 / t) = floor(n / t) * 256 + floor((n % t) * 256 / t).
   assign divisor  = (state_ff == ST_DIV_X) ? tgt_w_ff : tgt_h_ff;
   assign trial    = {rem_ff, dq_ff[DIV_W-1]};
   assign qbit     = (trial >= divisor);
   assign rem_next = qbit ? 8'(trial - divisor) : trial[7:0];
   assign dq_next  = {dq_ff[DIV_W-2:0], qbit};

   // The second neighbour is clamped to the last column and row of the source.
   assign x1_inc    = {1'b0, x1_ff} + 10'd1;
   assign y1_inc    = {1'b0, y1_ff} + 10'd1;
   assign x2        = (x1_inc >= {1'b0, src_w_ff}) ? src_w_ff - 9'd1 : x1_inc[8:0];
   assign y2        = (y1_inc >= {1'b0, src_h_ff}) ? src_h_ff - 9'd1 : y1_inc[8:0];
   assign fetch_col = nbr_ff[0] ? x2 : x1_ff;
   assign fetch_row = nbr_ff[1] ? y2 : y1_ff;
   assign fetch_addr = AW'(32'(fetch_row) * MAX_WIDTH + 32'(fetch_col));

   assign load_in_store = (32'(req_load_col) < MAX_WIDTH) && (32'(req_load_row) < MAX_HEIGHT);
   assign load_addr     = AW'(32'(req_load_row) * MAX_WIDTH + 32'(req_load_col));

   assign mem_we   = accept && (req_type == REQ_LOAD) && load_in_store;
   assign mem_addr = (state_ff == ST_FETCH) ? fetch_addr : load_addr;

   // Single-port store: one address each cycle, written on an accepted load and always read, read data registered.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= req_load_pixel;
      end
      rd_data_ff <= store_mem[mem_addr];
   end

   // Q1.16 weight of the neighbour being fetched: horizontal and vertical Q1.8 factors.
   assign wx          = nbr_ff[0] ? {1'b0, dx_ff} : 9'd256 - {1'b0, dx_ff};
   assign wy          = nbr_ff[1] ? {1'b0, dy_ff} : 9'd256 - {1'b0, dy_ff};
   assign weight_full = {9'd0, wx} * {9'd0, wy};

   // One product per color channel against the registered weight.
   assign prod_r = {17'd0, rd_data_ff[23:16]} * {8'd0, weight_ff};
   assign prod_g = {17'd0, rd_data_ff[15:8]}  * {8'd0, weight_ff};
   assign prod_b = {17'd0, rd_data_ff[7:0]}   * {8'd0, weight_ff};

   // State register and working registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= 5'd0;
         nbr_ff       <= 2'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         nbr_ff       <= nbr_in;
      end
      y_ff          <= y_in;
      dq_ff         <= dq_in;
      rem_ff        <= rem_in;
      x1_ff         <= x1_in;
      dx_ff         <= dx_in;
      y1_ff         <= y1_in;
      dy_ff         <= dy_in;
      weight_ff     <= weight_in;
      acc_r_ff      <= acc_r_in;
      acc_g_ff      <= acc_g_in;
      acc_b_ff      <= acc_b_in;
      rsp_pixel_ff  <= rsp_pixel_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Sequencer: divide x, divide y, fetch and blend one neighbour at a time, or copy one if nearest.
   always_comb begin
      state_in      = state_ff;
      y_in          = y_ff;
      dq_in         = dq_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      x1_in         = x1_ff;
      dx_in         = dx_ff;
      y1_in         = y1_ff;
      dy_in         = dy_ff;
      nbr_in        = nbr_ff;
      weight_in     = weight_ff;
      acc_r_in      = acc_r_ff;
      acc_g_in      = acc_g_ff;
      acc_b_in      = acc_b_ff;
      rsp_valid_in  = 1'b0;
      rsp_pixel_in  = rsp_pixel_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_type == REQ_COMPUTE)) begin
               if (({1'b0, req_out_col} >= tgt_w_ff) || ({1'b0, req_out_row} >= tgt_h_ff)) begin
                  // Target coordinate outside the target size: error result at once.
                  rsp_valid_in  = 1'b1;
                  rsp_pixel_in  = 32'd0;
                  rsp_status_in = STATUS_RANGE;
               end else begin
                  y_in     = req_out_row;
                  dq_in    = {17'({9'd0, req_out_col} * {8'd0, x_scale}), 8'd0};
                  rem_in   = 8'd0;
                  cnt_in   = 5'd0;
                  state_in = ST_DIV_X;
               end
            end
         end

         ST_DIV_X: begin
            dq_in  = dq_next;
            rem_in = rem_next;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(DIV_STEPS - 1)) begin
               x1_in    = dq_next[16:8];
               dx_in    = dq_next[7:0];
               dq_in    = {17'({9'd0, y_ff} * {8'd0, y_scale}), 8'd0};
               rem_in   = 8'd0;
               cnt_in   = 5'd0;
               state_in = ST_DIV_Y;
            end
         end

         ST_DIV_Y: begin
            dq_in  = dq_next;
            rem_in = rem_next;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(DIV_STEPS - 1)) begin
               y1_in    = dq_next[16:8];
               dy_in    = dq_next[7:0];
               cnt_in   = 5'd0;
               nbr_in   = 2'd0;
               // Half of one unit in Q8.16 makes the final shift round half up.
               acc_r_in = 24'd32768;
               acc_g_in = 24'd32768;
               acc_b_in = 24'd32768;
               state_in = ST_FETCH;
            end
         end

         ST_FETCH: begin
            // The store read is issued here; the weight lines up with the read data.
            weight_in = weight_full[16:0];
            state_in  = ST_MAC;
         end

         ST_MAC: begin
            acc_r_in = acc_r_ff + prod_r[23:0];
            acc_g_in = acc_g_ff + prod_g[23:0];
            acc_b_in = acc_b_ff + prod_b[23:0];
            if (mode_ff == MODE_NEAREST) begin
               // Nearest mode copies the source pixel, alpha included.
               rsp_valid_in  = 1'b1;
               rsp_pixel_in  = rd_data_ff;
               rsp_status_in = STATUS_OK;
               state_in      = ST_IDLE;
            end else if (nbr_ff == 2'd3) begin
               rsp_valid_in  = 1'b1;
               rsp_pixel_in  = {8'hFF, acc_r_in[23:16], acc_g_in[23:16], acc_b_in[23:16]};
               rsp_status_in = STATUS_OK;
               nbr_in        = 2'd0;
               state_in      = ST_IDLE;
            end else begin
               nbr_in   = nbr_ff + 2'd1;
               state_in = ST_FETCH;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: src/imrs_checker.sv
// Port-level checks of the image scaler and their binding to the top level.
module imrs_checker
   import imrs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_type,
   input logic        rsp_valid,
   input logic [31:0] rsp_result_pixel,
   input logic        rsp_status
);

   // An error result carries a zero pixel.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_RANGE)) |-> (rsp_result_pixel == 32'd0))
      else $error("error result with nonzero pixel");

   // A load word never produces a result and leaves the block ready.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type == REQ_LOAD)) |=> (!rsp_valid && !busy))
      else $error("load word produced a result or raised busy");

   // A compute word either starts work or returns an error result at once.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type == REQ_COMPUTE)) |=>
         (busy || (rsp_valid && (rsp_status == STATUS_RANGE))))
      else $error("compute word neither started nor rejected");

   // Finishing a computation always delivers a good result in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> (rsp_valid && (rsp_status == STATUS_OK)))
      else $error("busy fell without a result");

   // Results never appear while work is still in progress.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

endmodule

bind image_resize_bilinear_nearest imrs_checker u_imrs_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_type         (req_type),
   .rsp_valid        (rsp_valid),
   .rsp_result_pixel (rsp_result_pixel),
   .rsp_status       (rsp_status)
);

FILE: verif/testbench.sv
// Self-checking testbench of the image scaler: directed and random loads, computes and settings.
module testbench;
   import imrs_pkg::*;

   // The store is addressed as row * STORE_COLS + col, as in the block.
   localparam int          STORE_COLS   = 256;
   localparam int          STORE_DEPTH  = 65536;
   localparam logic [8:0]  SOURCE_LIMIT = 9'd256;
   // This hold-off outlasts a compute, so it covers any word still in flight.
   localparam int          HOLD_OFF     = 70;
   localparam int          CYCLE_LIMIT  = 1000000;
   localparam int          RANDOM_PHASES = 8;
   localparam int          PHASE_WORDS   = 30;

   typedef struct packed {
      bit [31:0] pixel;
      bit        status;
   } scaled_pixel_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic                   req_type;
   logic [7:0]             req_load_col;
   logic [7:0]             req_load_row;
   logic [31:0]            req_load_pixel;
   logic [7:0]             req_out_col;
   logic [7:0]             req_out_row;
   logic                   rsp_valid;
   logic [31:0]            rsp_result_pixel;
   logic                   rsp_status;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   image_resize_bilinear_nearest dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_load_col     (req_load_col),
      .req_load_row     (req_load_row),
      .req_load_pixel   (req_load_pixel),
      .req_out_col      (req_out_col),
      .req_out_row      (req_out_row),
      .rsp_valid        (rsp_valid),
      .rsp_result_pixel (rsp_result_pixel),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Our own copy of the settings and of the pixel store. The settings only change
   // while the block is idle, so at each accepted word they match the block's.
   bit [8:0]      src_width     = 9'd1;
   bit [8:0]      src_height    = 9'd1;
   bit [8:0]      tgt_width     = 9'd1;
   bit [8:0]      tgt_height    = 9'd1;
   bit            scale_mode_cfg = MODE_BILINEAR;
   bit [31:0]     source_image [0:STORE_DEPTH-1];
   bit            pixel_loaded [0:STORE_DEPTH-1];

   // Results that accepted compute words are still owed, oldest first.
   scaled_pixel_type scaled_pixels [$];
   int            mismatch_count = 0;
   int            cycle_count    = 0;
   int            burst_left     = 0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // A size of zero acts as one and a size beyond the limit saturates.
   function automatic bit [8:0] size_limit(input bit [8:0] value, input bit [8:0] limit);
      if (value == 9'd0) return 9'd1;
      if (value > limit) return limit;
      return value;
   endfunction

   // Finds the source pixels that a target pixel is built from. In nearest mode all
   // four points collapse onto one pixel and both fractions are zero. In bilinear
   // mode the second column and row are clamped to the edge of the source image.
   function automatic void locate(input bit [7:0] x, input bit [7:0] y,
                                  output int unsigned c1, output int unsigned c2,
                                  output int unsigned r1, output int unsigned r2,
                                  output int unsigned dx, output int unsigned dy);
      int unsigned xi, yi, sw, sh, tw, th, nx, ny;
      xi = x;
      yi = y;
      sw = src_width;
      sh = src_height;
      tw = tgt_width;
      th = tgt_height;
      if (scale_mode_cfg == MODE_NEAREST) begin
         c1 = (xi * (sw - 1)) / tw;
         r1 = (yi * (sh - 1)) / th;
         c2 = c1;
         r2 = r1;
         dx = 0;
         dy = 0;
      end else begin
         nx = xi * sw;
         ny = yi * sh;
         c1 = nx / tw;
         r1 = ny / th;
         dx = ((nx % tw) * 256) / tw;
         dy = ((ny % th) * 256) / th;
         c2 = (c1 + 1 >= sw) ? sw - 1 : c1 + 1;
         r2 = (r1 + 1 >= sh) ? sh - 1 : r1 + 1;
      end
   endfunction

   // One channel of the blend: Q1.16 weights summing to one, rounded half up.
   function automatic bit [7:0] blend_channel(input bit [7:0] a, input bit [7:0] b,
                                              input bit [7:0] c, input bit [7:0] d,
                                              input int unsigned w1, input int unsigned w2,
                                              input int unsigned w3, input int unsigned w4);
      bit [31:0] acc;
      acc = 32'd32768 + a * w1 + b * w2 + c * w3 + d * w4;
      return acc[23:16];
   endfunction

   // The pixel and status that the block owes for a compute word at (x, y).
   function automatic scaled_pixel_type scale_pixel(input bit [7:0] x, input bit [7:0] y);
      scaled_pixel_type res;
      int unsigned   c1, c2, r1, r2, dx, dy, w1, w2, w3, w4;
      bit [31:0]     p1, p2, p3, p4;
      res.pixel  = 32'd0;
      res.status = STATUS_RANGE;
      if (x >= tgt_width || y >= tgt_height) return res;
      res.status = STATUS_OK;
      locate(x, y, c1, c2, r1, r2, dx, dy);
      p1 = source_image[r1 * STORE_COLS + c1];
      if (scale_mode_cfg == MODE_NEAREST) begin
         // Nearest mode copies the source pixel, alpha included.
         res.pixel = p1;
         return res;
      end
      p2 = source_image[r1 * STORE_COLS + c2];
      p3 = source_image[r2 * STORE_COLS + c1];
      p4 = source_image[r2 * STORE_COLS + c2];
      w1 = (256 - dx) * (256 - dy);
      w2 = dx * (256 - dy);
      w3 = (256 - dx) * dy;
      w4 = dx * dy;
      res.pixel = {8'hFF,
                   blend_channel(p1[23:16], p2[23:16], p3[23:16], p4[23:16], w1, w2, w3, w4),
                   blend_channel(p1[15:8],  p2[15:8],  p3[15:8],  p4[15:8],  w1, w2, w3, w4),
                   blend_channel(p1[7:0],   p2[7:0],   p3[7:0],   p4[7:0],   w1, w2, w3, w4)};
      return res;
   endfunction

   // Lowers start at the next falling edge and holds it low; n sets the length of the gap.
   task automatic quiet(input int n);
      @(negedge clock);
      start <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // Sends one word. The sender works in bursts; before each burst there may be a gap
   // of random length, so that the next word lands on every phase of the block's
   // work. start stays high after acceptance: whoever drives the next falling edge
   // either raises it for the next word or lowers it.
   task automatic send_word(input bit kind, input bit [7:0] lcol, input bit [7:0] lrow,
                            input bit [31:0] lpix, input bit [7:0] ocol,
                            input bit [7:0] orow);
      int gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 2))
            0: gap = 0;
            1: gap = $urandom_range(1, 4);
            default: gap = $urandom_range(1, 70);
         endcase
         if (gap != 0) quiet(gap);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      start          <= 1'b1;
      req_type       <= kind;
      req_load_col   <= lcol;
      req_load_row   <= lrow;
      req_load_pixel <= lpix;
      req_out_col    <= ocol;
      req_out_row    <= orow;
      do @(posedge clock); while (busy !== 1'b0);
      if (kind == REQ_LOAD) begin
         source_image[lrow * STORE_COLS + lcol] = lpix;
         pixel_loaded[lrow * STORE_COLS + lcol] = 1'b1;
      end else begin
         scaled_pixels.push_back(scale_pixel(ocol, orow));
      end
   endtask

   // A load word; the fields that only a compute uses carry random values.
   task automatic send_load(input bit [7:0] col, input bit [7:0] row, input bit [31:0] pix);
      send_word(REQ_LOAD, col, row, pix, 8'($urandom), 8'($urandom));
   endtask

   // A compute word. Any source pixel it reads that was never loaded is loaded first
   // with random content, since reading an empty store entry has no defined result.
   task automatic send_compute(input bit [7:0] x, input bit [7:0] y);
      int unsigned c1, c2, r1, r2, dx, dy, col, row;
      int          k;
      if (x < tgt_width && y < tgt_height) begin
         locate(x, y, c1, c2, r1, r2, dx, dy);
         for (k = 0; k < 4; k++) begin
            col = k[0] ? c2 : c1;
            row = k[1] ? r2 : r1;
            if (!pixel_loaded[row * STORE_COLS + col]) send_load(8'(col), 8'(row), $urandom);
         end
      end
      send_word(REQ_COMPUTE, 8'($urandom), 8'($urandom), $urandom, x, y);
   endtask

   // Waits until every owed result has come, then lets the block run dry.
   task automatic settle();
      quiet(1);
      while (scaled_pixels.size() != 0) @(posedge clock);
      repeat (HOLD_OFF) @(negedge clock);
   endtask

   // Writes one register and mirrors the write in our copy of the settings.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input bit [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid      <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_SOURCE_WIDTH:  src_width  = size_limit(value, SOURCE_LIMIT);
         CSR_SOURCE_HEIGHT: src_height = size_limit(value, SOURCE_LIMIT);
         CSR_TARGET_WIDTH:  tgt_width  = size_limit(value, TARGET_LIMIT);
         CSR_TARGET_HEIGHT: tgt_height = size_limit(value, TARGET_LIMIT);
         CSR_SCALE_MODE:    scale_mode_cfg = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Brings the block to rest and writes all five registers. The mode word carries
   // random upper bits, which the block has to ignore.
   task automatic configure(input bit [8:0] sw, input bit [8:0] sh, input bit [8:0] tw,
                            input bit [8:0] th, input bit mode);
      settle();
      write_register(CSR_SOURCE_WIDTH, sw);
      write_register(CSR_SOURCE_HEIGHT, sh);
      write_register(CSR_TARGET_WIDTH, tw);
      write_register(CSR_TARGET_HEIGHT, th);
      write_register(CSR_SCALE_MODE, {8'($urandom), mode});
   endtask

   // Mostly small sizes, with zero, one, the maximum and oversized values mixed in.
   function automatic bit [8:0] pick_size();
      case ($urandom_range(0, 9))
         0: return 9'd0;
         1: return 9'd1;
         2: return 9'd256;
         3: return 9'($urandom_range(257, 511));
         default: return 9'($urandom_range(2, 24));
      endcase
   endfunction

   // Right after reset all sizes are one and the mode is bilinear.
   task automatic test_reset_defaults();
      send_load(8'd0, 8'd0, 32'h12345678);
      send_compute(8'd0, 8'd0);
      send_compute(8'd1, 8'd0);
      send_compute(8'd255, 8'd255);
   endtask

   // Zero sizes act as one, oversized ones saturate, and unknown indexes change nothing.
   task automatic test_register_bounds();
      int idx;
      configure(9'd0, 9'd0, 9'd0, 9'd0, MODE_NEAREST);
      send_compute(8'd0, 8'd0);
      send_compute(8'd0, 8'd1);
      configure(9'd511, 9'd300, 9'd511, 9'd257, MODE_BILINEAR);
      for (idx = int'(CSR_SCALE_MODE) + 1; idx < (1 << CSR_INDEX_W); idx++) begin
         write_register(CSR_INDEX_W'(idx), CSR_DATA_W'($urandom));
      end
      send_compute(8'd255, 8'd255);
      send_compute(8'd0, 8'd0);
      send_compute(8'd200, 8'd13);
   endtask

   // Nearest mode copies the pixel with its own alpha; a column past the target is an error.
   task automatic test_nearest_mode();
      configure(9'd7, 9'd5, 9'd3, 9'd9, MODE_NEAREST);
      send_load(8'd4, 8'd3, 32'h00A5C3E1);
      send_compute(8'd2, 8'd8);
      send_compute(8'd0, 8'd0);
      send_compute(8'd3, 8'd0);
   endtask

   // Bilinear blends with extreme pixel values, the clamped last column and row,
   // and a strong downscale.
   task automatic test_bilinear_mode();
      configure(9'd5, 9'd4, 9'd7, 9'd9, MODE_BILINEAR);
      send_load(8'd4, 8'd3, 32'hFFFFFFFF);
      send_load(8'd2, 8'd1, 32'h00000000);
      send_load(8'd3, 8'd1, 32'hFFFFFFFF);
      send_load(8'd2, 8'd2, 32'h7F80FF01);
      send_load(8'd3, 8'd2, 32'h00FF0080);
      send_compute(8'd6, 8'd8);
      send_compute(8'd3, 8'd4);
      configure(9'd200, 9'd150, 9'd3, 9'd2, MODE_BILINEAR);
      send_compute(8'd2, 8'd1);
      send_compute(8'd1, 8'd2);
   endtask

   // A pixel loaded outside the source size shows up once the source grows over it.
   task automatic test_hidden_load();
      configure(9'd4, 9'd4, 9'd4, 9'd4, MODE_NEAREST);
      send_load(8'd10, 8'd10, 32'hC0FFEE11);
      send_load(8'd255, 8'd255, 32'h80402010);
      configure(9'd11, 9'd11, 9'd11, 9'd11, MODE_BILINEAR);
      send_compute(8'd10, 8'd10);
   endtask

   // Random phases, each under its own setting; the first two are the extremes.
   // Most computes fall inside the target and a few anywhere in the coordinate range.
   task automatic test_random();
      int       phase, n;
      bit [7:0] a, b;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) begin
            configure(9'd256, 9'd256, 9'd256, 9'd256, MODE_BILINEAR);
         end else if (phase == 1) begin
            configure(9'd1, 9'd1, 9'd256, 9'd256, MODE_NEAREST);
         end else begin
            configure(pick_size(), pick_size(), pick_size(), pick_size(),
                      1'($urandom_range(0, 1)));
         end
         for (n = 0; n < PHASE_WORDS; n++) begin
            if ($urandom_range(0, 99) < 35) begin
               a = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, src_width - 1));
               b = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, src_height - 1));
               send_load(a, b, $urandom);
            end else begin
               a = 8'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, tgt_width - 1));
               b = 8'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, tgt_height - 1));
               send_compute(a, b);
            end
         end
      end
   endtask

   // Every result strobe is matched against the oldest owed result. The outputs are
   // read at the rising edge, before the block updates them for the next cycle.
   always @(posedge clock) begin : check_results
      scaled_pixel_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (scaled_pixels.size() == 0) begin
            $error("rsp_valid: no result owed, got pixel %h status %0d",
                   rsp_result_pixel, rsp_status);
            mismatch_count++;
         end else begin
            want = scaled_pixels.pop_front();
            if (rsp_result_pixel !== want.pixel) begin
               $error("result_pixel: expected %h, actual %h", want.pixel, rsp_result_pixel);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_type       = REQ_LOAD;
      req_load_col   = 8'd0;
      req_load_row   = 8'd0;
      req_load_pixel = 32'd0;
      req_out_col    = 8'd0;
      req_out_row    = 8'd0;
      csr_valid      = 1'b0;
      csr_index      = CSR_SOURCE_WIDTH;
      csr_write_data = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_register_bounds();
      test_nearest_mode();
      test_bilinear_mode();
      test_hidden_load();
      test_random();

      // Drain the last results and give the block time to show any stray strobe.
      settle();
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
